// ----- rtl/bam_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_pkg: shared types and constants
// Map page geometry, counter limits, register indexes and the control
// structs passed between the marker and its bitmap store.
// ----------------------------------------------------------------------------
package bam_pkg;

  // map page geometry (fixed by the 14-bit page counters)
  localparam int BLOCKS_PER_PAGE = 8192;
  localparam int PAGE_LOG2       = 13;

  // field widths
  localparam int BLK_W   = 16;
  localparam int PAGE_W  = 14;
  localparam int COUNT_W = 17;
  localparam int LG_W    = 5;
  localparam int CFG_W   = 17;

  // smallest allocation group, log2 blocks
  localparam logic [LG_W-1:0] MIN_GROUP_LOG2 = 5'd13;

  // saturation limits of the used counters
  localparam logic [PAGE_W-1:0]  PAGE_CNT_MAX  = 14'h3FFF;
  localparam logic [COUNT_W-1:0] GROUP_CNT_MAX = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] TOTAL_CNT_MAX = 17'h1FFFF;

  // bit of block 0 within a bitmap word (MSB first)
  localparam logic [31:0] TOP_BIT = 32'h8000_0000;

  // configuration register indexes
  localparam logic [0:0] CFG_MAP_SIZE   = 1'b0;
  localparam logic [0:0] CFG_GROUP_LOG2 = 1'b1;

  // commands to the bitmap store
  typedef struct packed {
    logic lookup;  // read the word and latch the bit mask
    logic commit;  // write the looked-up word back with the bit set
  } bam_bm_cmd_t;

  // status from the bitmap store
  typedef struct packed {
    logic clearing;  // reset sweep in progress
    logic hit;       // looked-up bit was already set
  } bam_bm_stat_t;

endpackage
`default_nettype wire

// ----- rtl/bam_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_in_if: mark request channel
// Valid/ready channel carrying one block to mark per item.
// ----------------------------------------------------------------------------
interface bam_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_number;
  logic        bad_block;

  modport source (output valid, output block_number, output bad_block, input ready);
  modport sink   (input valid, input block_number, input bad_block, output ready);
endinterface
`default_nettype wire

// ----- rtl/bam_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_out_if: mark result channel
// Valid/ready channel carrying one result item per mark request.
// ----------------------------------------------------------------------------
interface bam_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        already_marked;
  logic [13:0] page_free;
  logic [16:0] group_free;
  logic [16:0] total_free;
  logic [15:0] highest_allocated;

  modport source (output valid, output accepted, output already_marked,
                  output page_free, output group_free, output total_free,
                  output highest_allocated, input ready);
  modport sink   (input valid, input accepted, input already_marked,
                  input page_free, input group_free, input total_free,
                  input highest_allocated, output ready);
endinterface
`default_nettype wire

// ----- rtl/block_allocation_bitmap_marker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_allocation_bitmap_marker: allocation bitmap marker
// Marks blocks allocated in a bitmap and reports free counts per map page,
// per allocation group and in total, plus the highest good block marked.
// ----------------------------------------------------------------------------
// Usage:
//   blocks  : one item per block to mark (block_number, bad_block).
//   results : one item per request, in order (accepted, already_marked,
//             page_free, group_free, total_free, highest_allocated).
//   cfg_*   : register writes (index 0 map_size, 1 group_log2_size), taken
//             at any edge with cfg_we high; write only while idle.
// Sequence:
//   The bitmap word is read at the accept edge and written back with the bit
//   set, together with the counter updates, at the S_RMW edge that finds the
//   result register free, which also loads it. A new item waits until that
//   write-back, set by the read-then-write of the single bitmap memory.
// Reset:
//   Counters, highest mark and registers reset at once; the bitmap is then
//   zeroed one word a cycle over all MAX_BLOCKS/32 words, with blocks.ready
//   low. Config writes are taken during the sweep.
// Stall:
//   A result held by results.ready low blocks the next write-back; a new
//   item is accepted meanwhile and waits in the read stage.
// ----------------------------------------------------------------------------
module block_allocation_bitmap_marker
  import bam_pkg::*;
#(
  parameter int MAX_BLOCKS = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  bam_in_if.sink                blocks,
  bam_out_if.source             results
);

  localparam int WORDS     = MAX_BLOCKS / 32;
  localparam int WORD_AW   = $clog2(WORDS);
  localparam int CNT_DEPTH = (MAX_BLOCKS + BLOCKS_PER_PAGE - 1) / BLOCKS_PER_PAGE;
  localparam int CNT_AW    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_RMW  = 1'b1;

  // configuration registers
  logic [COUNT_W-1:0] map_size;
  logic [LG_W-1:0]    group_log2_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size        <= 17'h10000;
      group_log2_size <= MIN_GROUP_LOG2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_SIZE:   map_size        <= cfg_data;
        CFG_GROUP_LOG2: group_log2_size <= cfg_data[LG_W-1:0];
        default:        map_size        <= map_size;
      endcase
    end
  end

  // effective sizes
  logic [COUNT_W-1:0] eff_map;
  logic [LG_W-1:0]    eff_lg;

  always_comb begin
    eff_map = (32'(map_size) > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS) : map_size;
    eff_lg  = (group_log2_size < MIN_GROUP_LOG2) ? MIN_GROUP_LOG2 : group_log2_size;
  end

  // state
  logic [0:0]         state;
  logic [PAGE_W-1:0]  page_used  [CNT_DEPTH];
  logic [COUNT_W-1:0] group_used [CNT_DEPTH];
  logic [COUNT_W-1:0] total_used;
  logic [BLK_W-1:0]   highest_mark;

  // item context latched at accept
  logic               in_range_q;
  logic               word_ok_q;
  logic               bad_q;
  logic [BLK_W-1:0]   blk_q;
  logic [CNT_AW-1:0]  pidx_q;
  logic [CNT_AW-1:0]  gidx_q;
  logic [PAGE_W-1:0]  page_cap_q;
  logic [COUNT_W-1:0] group_cap_q;

  bam_bm_cmd_t  bm_cmd;
  bam_bm_stat_t bm_stat;

  logic accept;
  logic fire;

  assign blocks.ready = (state == S_IDLE) && !bm_stat.clearing;
  assign accept       = blocks.valid && blocks.ready;
  assign fire         = (state == S_RMW) && (!results.valid || results.ready);

  // address decode and span capacities of the incoming block
  logic [31:0]        blk32;
  logic               in_range;
  logic               word_ok;
  logic [31:0]        page_left;
  logic [31:0]        grp_left;
  logic [31:0]        grp_span;
  logic [PAGE_W-1:0]  page_cap;
  logic [COUNT_W-1:0] group_cap;

  always_comb begin
    blk32     = 32'(blocks.block_number);
    in_range  = blk32 < 32'(eff_map);
    word_ok   = (blk32 >> 5) < 32'(WORDS);
    page_left = 32'(eff_map) - (blk32 & ~32'(BLOCKS_PER_PAGE - 1));
    page_cap  = (page_left < 32'(BLOCKS_PER_PAGE)) ? page_left[PAGE_W-1:0]
                                                   : PAGE_W'(BLOCKS_PER_PAGE);
    grp_left  = 32'(eff_map) - (blk32 & (32'hFFFF_FFFF << eff_lg));
    grp_span  = 32'd1 << eff_lg;
    group_cap = (grp_left < grp_span) ? grp_left[COUNT_W-1:0] : grp_span[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_range_q  <= in_range;
      word_ok_q   <= word_ok;
      bad_q       <= blocks.bad_block;
      blk_q       <= blocks.block_number;
      pidx_q      <= blk32[CNT_AW+PAGE_LOG2-1:PAGE_LOG2];
      gidx_q      <= CNT_AW'(blk32 >> eff_lg);
      page_cap_q  <= page_cap;
      group_cap_q <= group_cap;
    end
  end

  // bitmap test-and-set; the single access sequence per item keeps the
  // lookup and write-back of one item from overlapping the next
  assign bm_cmd.lookup = accept && in_range && word_ok;
  assign bm_cmd.commit = fire && in_range_q && word_ok_q;

  bam_bitmap #(
    .WORDS (WORDS),
    .AW    (WORD_AW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .cmd     (bm_cmd),
    .addr    (blk32[WORD_AW+4:5]),
    .bit_sel (blocks.block_number[4:0]),
    .stat    (bm_stat)
  );

  // counter updates and free counts
  logic [PAGE_W-1:0]  page_cur, page_new, pfree;
  logic [COUNT_W-1:0] group_cur, group_new, gfree;
  logic [COUNT_W-1:0] total_new, tfree;
  logic [BLK_W-1:0]   highest_new;

  always_comb begin
    page_cur  = page_used[pidx_q];
    group_cur = group_used[gidx_q];
    page_new  = (page_cur >= PAGE_CNT_MAX) ? PAGE_CNT_MAX : page_cur + 1'b1;
    group_new = (group_cur >= GROUP_CNT_MAX) ? GROUP_CNT_MAX : group_cur + 1'b1;
    if (in_range_q) begin
      total_new = (total_used >= TOTAL_CNT_MAX) ? TOTAL_CNT_MAX : total_used + 1'b1;
    end else begin
      total_new = total_used;
    end
    pfree = (in_range_q && page_cap_q > page_new) ? page_cap_q - page_new : '0;
    gfree = (in_range_q && group_cap_q > group_new) ? group_cap_q - group_new : '0;
    tfree = (eff_map > total_new) ? eff_map - total_new : '0;
    highest_new = (in_range_q && !bad_q && blk_q > highest_mark) ? blk_q : highest_mark;
  end

  // control sequence and used counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total_used   <= '0;
      highest_mark <= '0;
      for (int i = 0; i < CNT_DEPTH; i++) begin
        page_used[i]  <= '0;
        group_used[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RMW;
          end
        end
        S_RMW: begin
          if (fire) begin
            state        <= S_IDLE;
            total_used   <= total_new;
            highest_mark <= highest_new;
            if (in_range_q) begin
              page_used[pidx_q]  <= page_new;
              group_used[gidx_q] <= group_new;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.accepted          <= in_range_q;
      results.already_marked    <= in_range_q && word_ok_q && bm_stat.hit;
      results.page_free         <= pfree;
      results.group_free        <= gfree;
      results.total_free        <= tfree;
      results.highest_allocated <= highest_new;
    end
  end

  // checks
  a_accept_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RMW))
    else $error("accepted item did not enter write-back");

  a_result_from_rmw: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> ($past(state) == S_RMW))
    else $error("result loaded outside write-back");

  a_dup_implies_acc: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.already_marked || results.accepted))
    else $error("already_marked on a rejected block");

  a_page_free_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.page_free <= PAGE_W'(BLOCKS_PER_PAGE)))
    else $error("page_free above page size");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    bm_stat.clearing |-> !bm_cmd.commit)
    else $error("write-back during bitmap sweep");

endmodule
`default_nettype wire

// ----- rtl/bam_bitmap.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_bitmap: allocation bitmap store
// One-port-write, registered-read memory of 32-bit words with a test-and-set
// access in lookup and commit steps, and a zero sweep of all words after reset.
// ----------------------------------------------------------------------------
module bam_bitmap
  import bam_pkg::*;
#(
  parameter int WORDS = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bam_bm_cmd_t   cmd,
  input  wire logic [AW-1:0] addr,
  input  wire logic [4:0]    bit_sel,
  output      bam_bm_stat_t  stat
);

  logic [31:0]   mem [WORDS];
  logic [31:0]   rdata;
  logic [31:0]   mask;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] clr_addr;
  logic          clearing;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  // write port: reset sweep has priority over write-back
  always_comb begin
    we    = clearing | cmd.commit;
    waddr = clearing ? clr_addr : addr_q;
    wdata = clearing ? 32'h0 : (rdata | mask);
  end

  // memory array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.lookup) begin
      rdata <= mem[addr];
    end
  end

  // lookup context for the write-back
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      addr_q <= addr;
      mask   <= TOP_BIT >> bit_sel;
    end
  end

  // zero sweep after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign stat.clearing = clearing;
  assign stat.hit      = |(rdata & mask);

endmodule
`default_nettype wire
